@@ rtl/depth_island_removal_filter_defines.svh @@
// Assertion macros shared by the island removal filter RTL.
`ifndef DEPTH_ISLAND_REMOVAL_FILTER_DEFINES_SVH
`define DEPTH_ISLAND_REMOVAL_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define DIRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication.
`define DIRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define DIRF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DIRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/dirf_pkg.sv @@
// Shared widths, command codes, register indexes and flag codes of the island filter.
package dirf_pkg;

    localparam int CMD_W      = 2;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int MIN_W      = 17;
    localparam int WIN_W      = 4;
    localparam int THR_W      = 16;
    localparam int IMG_W      = 9;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    typedef logic [1:0]           t_flags;

    // Input commands; the spare code is ignored
    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_RUN   = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;
    localparam t_cmd CMD_SPARE = 2'd3;

    // Configuration register indexes
    localparam t_reg_idx REG_MIN_SIZE  = 3'd0;
    localparam t_reg_idx REG_WINDOW    = 3'd1;
    localparam t_reg_idx REG_THRESHOLD = 3'd2;
    localparam t_reg_idx REG_DEPTH_ONLY = 3'd3;
    localparam t_reg_idx REG_IMG_WIDTH = 3'd4;
    localparam t_reg_idx REG_IMG_HEIGHT = 3'd5;

    // Register reset values
    localparam logic [MIN_W-1:0] RST_MIN_SIZE   = 17'd1000;
    localparam logic [WIN_W-1:0] RST_WINDOW     = 4'd3;
    localparam logic [THR_W-1:0] RST_THRESHOLD  = 16'd50;
    localparam logic             RST_DEPTH_ONLY = 1'b1;
    localparam logic [IMG_W-1:0] RST_IMG_WIDTH  = 9'd256;
    localparam logic [IMG_W-1:0] RST_IMG_HEIGHT = 9'd256;

    // Result kinds
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Per-point flags: bit 1 removed, bit 0 visited
    localparam t_flags FL_CLEAR   = 2'b00;
    localparam t_flags FL_VISITED = 2'b01;
    localparam t_flags FL_REMOVED = 2'b11;

endpackage

@@ rtl/dirf_in_if.sv @@
// Command channel: one point write, run or read request per beat.
interface dirf_in_if #(parameter int COORD_BITS = 16);
    logic                               valid;
    logic                               ready;
    logic [dirf_pkg::CMD_W-1:0]         cmd;
    logic [dirf_pkg::PIX_W-1:0]         pixel_index;
    logic signed [COORD_BITS-1:0]       coord_x;
    logic signed [COORD_BITS-1:0]       coord_y;
    logic signed [COORD_BITS-1:0]       coord_z;

    modport source (output valid, cmd, pixel_index, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, cmd, pixel_index, coord_x, coord_y, coord_z, output ready);
endinterface

@@ rtl/dirf_out_if.sv @@
// Result channel: run completion or filtered point per beat.
interface dirf_out_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         was_removed;

    modport source (output valid, result_kind, out_x, out_y, out_z, was_removed, input ready);
    modport sink   (input valid, result_kind, out_x, out_y, out_z, was_removed, output ready);
endinterface

@@ rtl/dirf_cfg_if.sv @@
// Configuration write channel: register index and data per beat.
interface dirf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dirf_pkg::CFG_IDX_W-1:0]      index;
    logic [dirf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/depth_island_removal_filter.sv @@
// Island removal filter over an organized point image, built around three RAMs of one entry per pixel.
//
// Channels: i_in carries commands (write point, run filter, read filtered point),
// o_out carries results, i_cfg writes the six configuration registers (always ready).
// Write beats are taken one per cycle while idle and return nothing. An in-range read's
// result passes through the RAM address register, the RAM read and the output register.
// A run first sweeps all MAX_WIDTH*MAX_HEIGHT flag RAM entries clear, one entry a cycle,
// then walks the image: it reads and checks each seed pixel, fetches each region member's
// list entry and centre point, skips window cells outside the image and reads and compares
// those inside it (depth mode is the short path, Euclidean goes through one shared squaring
// multiplier), checks each region's size at its end and marks each member of a region that
// gets removed. The run ends with one completion beat. All RAM reads are registered.
// A held result sits in the output register: write beats are still taken, while reads
// and runs wait for the receiver to take it. Reset returns the control to idle, empties
// the output register and loads the register defaults; the point RAM keeps its contents
// and is undefined until written, and every point reads as kept until the first run.
module depth_island_removal_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WINDOW = 15,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dirf_in_if.sink     i_in,
    dirf_out_if.source  o_out,
    dirf_cfg_if.sink    i_cfg
);
    import dirf_pkg::*;
    `include "depth_island_removal_filter_defines.svh"

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDXB     = $clog2(DEPTH);
    localparam int RB       = $clog2(MAX_HEIGHT);
    localparam int CLB      = $clog2(MAX_WIDTH);
    localparam int WB       = $clog2(MAX_WIDTH + 1);
    localparam int HGB      = $clog2(MAX_HEIGHT + 1);
    localparam int HALF_MAX = MAX_WINDOW / 2;
    localparam int HB       = $clog2(HALF_MAX + 1);
    localparam int LB       = IDXB + 1;
    localparam int EW       = IDXB + RB + CLB;
    localparam int CB       = COORD_BITS;
    localparam int PW       = 3 * CB;
    localparam int DW       = CB + 1;
    localparam int AW       = 2 * DW + 2;
    localparam int TSQW     = 2 * THR_W;
    localparam int SQW      = (AW > TSQW) ? AW : TSQW;
    localparam int XW       = ((IDXB > PIX_W) ? IDXB : PIX_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_RD_OUT, S_CLEAR,
        S_SEED_RD, S_SEED_WAIT, S_SEED_CHK, S_SEED_NEXT,
        S_CTR_RD, S_CTR_WAIT, S_CTR_PT, S_CTR_PTW, S_CTR_LATCH,
        S_NB_ADDR, S_NB_RD, S_NB_WAIT, S_NB_CHK, S_NB_DEPTH,
        S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQ_SUM, S_SQ_CMP,
        S_JOIN, S_NB_NEXT, S_REG_END, S_RM_RD, S_RM_WAIT, S_RM_WR, S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [MIN_W-1:0] r_min;
    logic [WIN_W-1:0] r_win;
    logic [THR_W-1:0] r_thr;
    logic             r_donly;
    logic [IMG_W-1:0] r_imgw;
    logic [IMG_W-1:0] r_imgh;

    // Run geometry, latched at the run command
    logic [WB-1:0]  r_w;
    logic [HGB-1:0] r_h;
    logic [HB-1:0]  r_half;

    // Flag RAM holds defined contents once a run has swept it
    logic           r_flags_ok;

    // RAMs and their port registers
    logic [PW-1:0]   m_point [DEPTH];
    logic [1:0]      m_flags [DEPTH];
    logic [EW-1:0]   m_list  [DEPTH];

    logic            r_pt_we;
    logic [IDXB-1:0] r_pt_waddr;
    logic [PW-1:0]   r_pt_wdata;
    logic [IDXB-1:0] r_pt_raddr;
    logic [PW-1:0]   r_pt_q;

    logic            r_fl_we;
    logic [IDXB-1:0] r_fl_waddr;
    t_flags          r_fl_wdata;
    logic [IDXB-1:0] r_fl_raddr;
    t_flags          r_fl_q;

    logic            r_ls_we;
    logic [IDXB-1:0] r_ls_waddr;
    logic [EW-1:0]   r_ls_wdata;
    logic [IDXB-1:0] r_ls_raddr;
    logic [EW-1:0]   r_ls_q;

    // Walk state
    logic [IDXB-1:0] r_cidx;
    logic [IDXB-1:0] r_sidx;
    logic [RB-1:0]   r_srow;
    logic [CLB-1:0]  r_scol;
    logic [LB-1:0]   r_head;
    logic [LB-1:0]   r_tail;
    logic [LB-1:0]   r_ri;
    logic [RB-1:0]   r_crow;
    logic [CLB-1:0]  r_ccol;
    logic signed [CB-1:0] r_cx;
    logic signed [CB-1:0] r_cy;
    logic signed [CB-1:0] r_cz;
    logic signed [HB:0]   r_wy;
    logic signed [HB:0]   r_wx;
    logic [IDXB-1:0] r_n;
    logic [RB-1:0]   r_py;
    logic [CLB-1:0]  r_px;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [DW-1:0] r_dz;
    logic [2*DW-1:0] r_prod;
    logic [AW-1:0]   r_acc;
    logic [TSQW-1:0] r_tsq;

    // Output register
    logic            r_out_valid;
    logic            r_out_kind;
    logic signed [CB-1:0] r_out_x;
    logic signed [CB-1:0] r_out_y;
    logic signed [CB-1:0] r_out_z;
    logic            r_out_removed;

    // Combinational helpers
    logic                 in_ready;
    logic                 in_acc;
    logic [XW-1:0]        in_idx_ext;
    logic                 in_range;
    logic [IDXB-1:0]      in_addr;
    logic signed [CB-1:0] pt_x;
    logic signed [CB-1:0] pt_y;
    logic signed [CB-1:0] pt_z;
    logic                 rd_removed;
    logic signed [HB:0]   half_s;
    logic signed [RB+1:0] nb_py;
    logic signed [CLB+1:0] nb_px;
    logic                 nb_in;
    logic [IDXB-1:0]      nb_idx;
    logic [DW-1:0]        adz;
    logic signed [DW-1:0] mul_op;
    logic signed [2*DW-1:0] mul_res;
    logic [IDXB-1:0]      ent_idx;
    logic [RB-1:0]        ent_row;
    logic [CLB-1:0]       ent_col;
    logic [WB-1:0]        sat_w;
    logic [HGB-1:0]       sat_h;
    logic [HB-1:0]        sat_half;

    // Accept reads and runs only with the output register free
    assign in_ready = (r_state == S_IDLE) &&
                      (!r_out_valid || ((i_in.cmd != CMD_RUN) && (i_in.cmd != CMD_READ)));
    assign in_acc   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    assign in_idx_ext = XW'(i_in.pixel_index);
    assign in_range   = (in_idx_ext < XW'(DEPTH));
    assign in_addr    = in_idx_ext[IDXB-1:0];

    assign pt_x = r_pt_q[CB-1:0];
    assign pt_y = r_pt_q[2*CB-1:CB];
    assign pt_z = r_pt_q[3*CB-1:2*CB];

    // A point counts as removed only after a run has cleared the flags
    assign rd_removed = r_flags_ok & r_fl_q[1];

    assign ent_idx = r_ls_q[EW-1 -: IDXB];
    assign ent_row = r_ls_q[CLB +: RB];
    assign ent_col = r_ls_q[CLB-1:0];

    // Saturate image size and window at run start
    assign sat_w    = (int'(r_imgw) > MAX_WIDTH)  ? WB'(MAX_WIDTH)   : WB'(r_imgw);
    assign sat_h    = (int'(r_imgh) > MAX_HEIGHT) ? HGB'(MAX_HEIGHT) : HGB'(r_imgh);
    assign sat_half = (int'(r_win) > MAX_WINDOW)  ? HB'(HALF_MAX)    : HB'(r_win >> 1);

    // Neighbour position, bounds and row-major index
    assign half_s = $signed({1'b0, r_half});
    assign nb_py  = $signed({2'b00, r_crow}) + (RB+2)'(r_wy);
    assign nb_px  = $signed({2'b00, r_ccol}) + (CLB+2)'(r_wx);
    assign nb_in  = !nb_py[RB+1] && (int'(nb_py) < int'(r_h)) &&
                    !nb_px[CLB+1] && (int'(nb_px) < int'(r_w));
    assign nb_idx = IDXB'({{WB{1'b0}}, nb_py[RB-1:0]} * {{RB{1'b0}}, r_w}) +
                    IDXB'(nb_px[CLB-1:0]);

    assign adz = r_dz[DW-1] ? DW'(-r_dz) : DW'(r_dz);

    // Shared squaring multiplier
    always_comb begin
        case (r_state)
            S_SQ_X:  mul_op = r_dx;
            S_SQ_Y:  mul_op = r_dy;
            default: mul_op = r_dz;
        endcase
    end
    assign mul_res = mul_op * mul_op;

    // Point RAM
    always_ff @(posedge i_clk) begin
        if (r_pt_we) begin
            m_point[r_pt_waddr] <= r_pt_wdata;
        end
        r_pt_q <= m_point[r_pt_raddr];
    end

    // Visited / removed flag RAM
    always_ff @(posedge i_clk) begin
        if (r_fl_we) begin
            m_flags[r_fl_waddr] <= r_fl_wdata;
        end
        r_fl_q <= m_flags[r_fl_raddr];
    end

    // Region list RAM
    always_ff @(posedge i_clk) begin
        if (r_ls_we) begin
            m_list[r_ls_waddr] <= r_ls_wdata;
        end
        r_ls_q <= m_list[r_ls_raddr];
    end

    // Squared threshold for Euclidean mode
    always_ff @(posedge i_clk) begin
        r_tsq <= r_thr * r_thr;
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pt_we     <= 1'b0;
            r_fl_we     <= 1'b0;
            r_ls_we     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_flags_ok  <= 1'b0;
            r_min       <= RST_MIN_SIZE;
            r_win       <= RST_WINDOW;
            r_thr       <= RST_THRESHOLD;
            r_donly     <= RST_DEPTH_ONLY;
            r_imgw      <= RST_IMG_WIDTH;
            r_imgh      <= RST_IMG_HEIGHT;
        end else begin
            r_pt_we <= 1'b0;
            r_fl_we <= 1'b0;
            r_ls_we <= 1'b0;

            // Register writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MIN_SIZE:   r_min   <= i_cfg.data[MIN_W-1:0];
                    REG_WINDOW:     r_win   <= i_cfg.data[WIN_W-1:0];
                    REG_THRESHOLD:  r_thr   <= i_cfg.data[THR_W-1:0];
                    REG_DEPTH_ONLY: r_donly <= i_cfg.data[0];
                    REG_IMG_WIDTH:  r_imgw  <= i_cfg.data[IMG_W-1:0];
                    REG_IMG_HEIGHT: r_imgh  <= i_cfg.data[IMG_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.cmd)
                            CMD_WRITE: begin
                                if (in_range) begin
                                    r_pt_we    <= 1'b1;
                                    r_pt_waddr <= in_addr;
                                    r_pt_wdata <= {i_in.coord_z, i_in.coord_y, i_in.coord_x};
                                end
                            end
                            CMD_RUN: begin
                                r_w     <= sat_w;
                                r_h     <= sat_h;
                                r_half  <= sat_half;
                                r_cidx  <= '0;
                                r_state <= S_CLEAR;
                            end
                            CMD_READ: begin
                                if (in_range) begin
                                    r_pt_raddr <= in_addr;
                                    r_fl_raddr <= in_addr;
                                    r_state    <= S_RD_WAIT;
                                end else begin
                                    r_out_valid   <= 1'b1;
                                    r_out_kind    <= KIND_READ;
                                    r_out_x       <= '0;
                                    r_out_y       <= '0;
                                    r_out_z       <= '0;
                                    r_out_removed <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_WAIT: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    r_out_valid   <= 1'b1;
                    r_out_kind    <= KIND_READ;
                    r_out_removed <= rd_removed;
                    r_out_x       <= rd_removed ? '0 : pt_x;
                    r_out_y       <= rd_removed ? '0 : pt_y;
                    r_out_z       <= rd_removed ? '0 : pt_z;
                    r_state       <= S_IDLE;
                end
                // Sweep the flag RAM clear
                S_CLEAR: begin
                    r_fl_we    <= 1'b1;
                    r_fl_waddr <= r_cidx;
                    r_fl_wdata <= FL_CLEAR;
                    if (r_cidx == IDXB'(DEPTH - 1)) begin
                        r_flags_ok <= 1'b1;
                        r_sidx <= '0;
                        r_srow <= '0;
                        r_scol <= '0;
                        if ((r_w == '0) || (r_h == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SEED_RD;
                        end
                    end else begin
                        r_cidx <= r_cidx + 1'b1;
                    end
                end
                S_SEED_RD: begin
                    r_pt_raddr <= r_sidx;
                    r_fl_raddr <= r_sidx;
                    r_state    <= S_SEED_WAIT;
                end
                S_SEED_WAIT: r_state <= S_SEED_CHK;
                // Start a region at a fresh valid point
                S_SEED_CHK: begin
                    if ((pt_z == '0) || r_fl_q[0]) begin
                        r_state <= S_SEED_NEXT;
                    end else begin
                        r_ls_we    <= 1'b1;
                        r_ls_waddr <= '0;
                        r_ls_wdata <= {r_sidx, r_srow, r_scol};
                        r_fl_we    <= 1'b1;
                        r_fl_waddr <= r_sidx;
                        r_fl_wdata <= FL_VISITED;
                        r_head     <= '0;
                        r_tail     <= LB'(1);
                        r_state    <= S_CTR_RD;
                    end
                end
                S_SEED_NEXT: begin
                    r_sidx  <= r_sidx + 1'b1;
                    r_state <= S_SEED_RD;
                    if (int'(r_scol) == int'(r_w) - 1) begin
                        r_scol <= '0;
                        if (int'(r_srow) == int'(r_h) - 1) begin
                            r_state <= S_DONE;
                        end else begin
                            r_srow <= r_srow + 1'b1;
                        end
                    end else begin
                        r_scol <= r_scol + 1'b1;
                    end
                end
                // Fetch the next region member and its point
                S_CTR_RD: begin
                    r_ls_raddr <= r_head[IDXB-1:0];
                    r_state    <= S_CTR_WAIT;
                end
                S_CTR_WAIT: r_state <= S_CTR_PT;
                S_CTR_PT: begin
                    r_crow     <= ent_row;
                    r_ccol     <= ent_col;
                    r_pt_raddr <= ent_idx;
                    r_state    <= S_CTR_PTW;
                end
                S_CTR_PTW: r_state <= S_CTR_LATCH;
                S_CTR_LATCH: begin
                    r_cx    <= pt_x;
                    r_cy    <= pt_y;
                    r_cz    <= pt_z;
                    r_wy    <= -half_s;
                    r_wx    <= -half_s;
                    r_state <= S_NB_ADDR;
                end
                // Scan the window around the member
                S_NB_ADDR: begin
                    if (nb_in) begin
                        r_n     <= nb_idx;
                        r_py    <= nb_py[RB-1:0];
                        r_px    <= nb_px[CLB-1:0];
                        r_state <= S_NB_RD;
                    end else begin
                        r_state <= S_NB_NEXT;
                    end
                end
                S_NB_RD: begin
                    r_pt_raddr <= r_n;
                    r_fl_raddr <= r_n;
                    r_state    <= S_NB_WAIT;
                end
                S_NB_WAIT: r_state <= S_NB_CHK;
                S_NB_CHK: begin
                    if (r_fl_q[0] || (pt_z == '0)) begin
                        r_state <= S_NB_NEXT;
                    end else begin
                        r_dx    <= DW'(r_cx) - DW'(pt_x);
                        r_dy    <= DW'(r_cy) - DW'(pt_y);
                        r_dz    <= DW'(r_cz) - DW'(pt_z);
                        r_state <= r_donly ? S_NB_DEPTH : S_SQ_X;
                    end
                end
                S_NB_DEPTH: begin
                    r_state <= (int'(adz) <= int'(r_thr)) ? S_JOIN : S_NB_NEXT;
                end
                // Sum of squares through the shared multiplier
                S_SQ_X: begin
                    r_prod  <= unsigned'(mul_res);
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_acc   <= AW'(r_prod);
                    r_prod  <= unsigned'(mul_res);
                    r_state <= S_SQ_Z;
                end
                S_SQ_Z: begin
                    r_acc   <= r_acc + AW'(r_prod);
                    r_prod  <= unsigned'(mul_res);
                    r_state <= S_SQ_SUM;
                end
                S_SQ_SUM: begin
                    r_acc   <= r_acc + AW'(r_prod);
                    r_state <= S_SQ_CMP;
                end
                S_SQ_CMP: begin
                    r_state <= (SQW'(r_acc) <= SQW'(r_tsq)) ? S_JOIN : S_NB_NEXT;
                end
                // Append the neighbour and mark it visited
                S_JOIN: begin
                    r_ls_we    <= 1'b1;
                    r_ls_waddr <= r_tail[IDXB-1:0];
                    r_ls_wdata <= {r_n, r_py, r_px};
                    r_fl_we    <= 1'b1;
                    r_fl_waddr <= r_n;
                    r_fl_wdata <= FL_VISITED;
                    r_tail     <= r_tail + 1'b1;
                    r_state    <= S_NB_NEXT;
                end
                S_NB_NEXT: begin
                    if (r_wx == half_s) begin
                        r_wx <= -half_s;
                        if (r_wy == half_s) begin
                            r_head  <= r_head + 1'b1;
                            r_state <= ((r_head + 1'b1) < r_tail) ? S_CTR_RD : S_REG_END;
                        end else begin
                            r_wy    <= r_wy + 1'b1;
                            r_state <= S_NB_ADDR;
                        end
                    end else begin
                        r_wx    <= r_wx + 1'b1;
                        r_state <= S_NB_ADDR;
                    end
                end
                S_REG_END: begin
                    r_ri <= '0;
                    if ((r_min != '0) && (int'(r_tail) < int'(r_min))) begin
                        r_state <= S_RM_RD;
                    end else begin
                        r_state <= S_SEED_NEXT;
                    end
                end
                // Mark every member of a small region removed
                S_RM_RD: begin
                    r_ls_raddr <= r_ri[IDXB-1:0];
                    r_state    <= S_RM_WAIT;
                end
                S_RM_WAIT: r_state <= S_RM_WR;
                S_RM_WR: begin
                    r_fl_we    <= 1'b1;
                    r_fl_waddr <= ent_idx;
                    r_fl_wdata <= FL_REMOVED;
                    r_ri       <= r_ri + 1'b1;
                    r_state    <= ((r_ri + 1'b1) == r_tail) ? S_SEED_NEXT : S_RM_RD;
                end
                S_DONE: begin
                    r_out_valid   <= 1'b1;
                    r_out_kind    <= KIND_RUN;
                    r_out_x       <= '0;
                    r_out_y       <= '0;
                    r_out_z       <= '0;
                    r_out_removed <= 1'b0;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.out_x       = r_out_x;
    assign o_out.out_y       = r_out_y;
    assign o_out.out_z       = r_out_z;
    assign o_out.was_removed = r_out_removed;

    // A member is fetched only while the region list still holds unprocessed entries
    `DIRF_ASSERT_IMPL(a_head_below_tail, i_clk, i_rst_n, r_state == S_CTR_RD, r_head < r_tail)
    // The region list never outgrows the image store
    `DIRF_ASSERT_IMPL(a_tail_bound, i_clk, i_rst_n, 1'b1, int'(r_tail) <= DEPTH)
    // The run completion beat finds the output register empty
    `DIRF_ASSERT_IMPL(a_done_out_free, i_clk, i_rst_n, r_state == S_DONE, !r_out_valid)
    // A join appends the point and marks that same point visited
    `DIRF_ASSERT_NEXT(a_join_marks, i_clk, i_rst_n, r_state == S_JOIN, r_fl_we && r_ls_we && (r_fl_wdata == FL_VISITED) && (r_fl_waddr == r_ls_wdata[EW-1 -: IDXB]))

endmodule

@@ sim/tb_depth_island_removal_filter.sv @@
// Self-checking testbench for the island removal filter: random command traffic against a scoreboard.
module tb_depth_island_removal_filter;
    import dirf_pkg::*;

    localparam int STORE = 65536;
    localparam int LIMIT_CYCLES = 8_000_000;

    typedef struct packed {
        t_cmd               cmd;
        logic [PIX_W-1:0]   idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } cmd_beat_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               removed;
    } filt_result_t;

    // Island filter predictor and queue of results still owed by the block
    class island_scoreboard;
        logic signed [15:0] pt_x[STORE];
        logic signed [15:0] pt_y[STORE];
        logic signed [15:0] pt_z[STORE];
        bit visited[STORE];
        bit removed[STORE];
        int members[$];
        logic [MIN_W-1:0] min_size = RST_MIN_SIZE;
        logic [WIN_W-1:0] win = RST_WINDOW;
        logic [THR_W-1:0] thr = RST_THRESHOLD;
        logic             depth_mode = RST_DEPTH_ONLY;
        logic [IMG_W-1:0] img_w = RST_IMG_WIDTH;
        logic [IMG_W-1:0] img_h = RST_IMG_HEIGHT;
        filt_result_t owed[$];

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_MIN_SIZE:   min_size = v[MIN_W-1:0];
                REG_WINDOW:     win = v[WIN_W-1:0];
                REG_THRESHOLD:  thr = v[THR_W-1:0];
                REG_DEPTH_ONLY: depth_mode = v[0];
                REG_IMG_WIDTH:  img_w = v[IMG_W-1:0];
                REG_IMG_HEIGHT: img_h = v[IMG_W-1:0];
                default: ;
            endcase
        endfunction

        function bit joins(int a, int b);
            longint dx, dy, dz, t;
            dx = longint'(pt_x[a]) - longint'(pt_x[b]);
            dy = longint'(pt_y[a]) - longint'(pt_y[b]);
            dz = longint'(pt_z[a]) - longint'(pt_z[b]);
            t = longint'(thr);
            if (depth_mode)
                return (dz < 0 ? -dz : dz) <= t;
            return dx * dx + dy * dy + dz * dz <= t * t;
        endfunction

        // Breadth-first region growing over the image in use
        function void find_islands();
            int w, h, half, total, head, c, cx, cy, nx, ny, n;
            w = (img_w > 256) ? 256 : int'(img_w);
            h = (img_h > 256) ? 256 : int'(img_h);
            half = int'(win) >> 1;
            total = w * h;
            for (int i = 0; i < STORE; i++) begin
                visited[i] = 0;
                removed[i] = 0;
            end
            for (int s = 0; s < total; s++) begin
                if (pt_z[s] == 0 || visited[s]) continue;
                members.delete();
                members.insert(members.size(), s);
                visited[s] = 1;
                head = 0;
                while (head < members.size()) begin
                    c = members[head];
                    cy = c / w;
                    cx = c - cy * w;
                    for (int dy = -half; dy <= half; dy++) begin
                        for (int dx = -half; dx <= half; dx++) begin
                            nx = cx + dx;
                            ny = cy + dy;
                            if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
                            n = ny * w + nx;
                            if (visited[n] || pt_z[n] == 0) continue;
                            if (!joins(c, n)) continue;
                            members.insert(members.size(), n);
                            visited[n] = 1;
                        end
                    end
                    head++;
                end
                if (min_size != 0 && members.size() < min_size)
                    foreach (members[i]) removed[members[i]] = 1;
            end
        endfunction

        function void note_cmd(cmd_beat_t b);
            filt_result_t r;
            r = '0;
            case (b.cmd)
                CMD_WRITE: begin
                    pt_x[b.idx] = b.x;
                    pt_y[b.idx] = b.y;
                    pt_z[b.idx] = b.z;
                end
                CMD_RUN: begin
                    find_islands();
                    r.kind = KIND_RUN;
                    owed.insert(owed.size(), r);
                end
                CMD_READ: begin
                    r.kind = KIND_READ;
                    if (removed[b.idx]) r.removed = 1;
                    else begin
                        r.x = pt_x[b.idx];
                        r.y = pt_y[b.idx];
                        r.z = pt_z[b.idx];
                    end
                    owed.insert(owed.size(), r);
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void check(filt_result_t got, ref string errs[$]);
            filt_result_t exp_r;
            exp_r = owed.pop_front();
            if (got.kind !== exp_r.kind)
                errs.insert(errs.size(),
                            $sformatf("result_kind %0d, want %0d", got.kind, exp_r.kind));
            if (got.x !== exp_r.x)
                errs.insert(errs.size(), $sformatf("out_x %0d, want %0d", got.x, exp_r.x));
            if (got.y !== exp_r.y)
                errs.insert(errs.size(), $sformatf("out_y %0d, want %0d", got.y, exp_r.y));
            if (got.z !== exp_r.z)
                errs.insert(errs.size(), $sformatf("out_z %0d, want %0d", got.z, exp_r.z));
            if (got.removed !== exp_r.removed)
                errs.insert(errs.size(), $sformatf("was_removed %0d, want %0d",
                                                   got.removed, exp_r.removed));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    dirf_in_if  #(.COORD_BITS(16)) in_ch ();
    dirf_out_if #(.COORD_BITS(16)) out_ch ();
    dirf_cfg_if cfg_ch ();

    depth_island_removal_filter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    island_scoreboard sb;
    int  errors = 0;
    bit  steady = 0;
    bit  hold_req = 0;
    bit  written[STORE];
    int  written_list[$];
    int  area = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 4);
        $display("FAIL depth_island_removal_filter");
        $finish;
    end

    task automatic report(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Watch both channels and the config port at the rising edge
    always @(posedge i_clk) begin
        string errs[$];
        filt_result_t got;
        errs.delete();
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_cmd({in_ch.cmd, in_ch.pixel_index, in_ch.coord_x, in_ch.coord_y,
                             in_ch.coord_z});
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.result_kind, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                       out_ch.was_removed};
                if (sb.pending() == 0) report("result beat with nothing expected");
                else begin
                    sb.check(got, errs);
                    foreach (errs[i]) report(errs[i]);
                end
            end
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                gap = 300;
                hold_req = 0;
            end else gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send(cmd_beat_t b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1;
        in_ch.cmd         <= b.cmd;
        in_ch.pixel_index <= b.idx;
        in_ch.coord_x     <= b.x;
        in_ch.coord_y     <= b.y;
        in_ch.coord_z     <= b.z;
        if (b.cmd == CMD_WRITE && !written[b.idx]) begin
            written[b.idx] = 1;
            written_list.insert(written_list.size(), int'(b.idx));
        end
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Clustered point content so that regions of several sizes form
    function automatic cmd_beat_t make_point(int idx);
        cmd_beat_t b;
        int r;
        logic signed [15:0] bases[4] = '{-16'sd20000, 16'sd300, 16'sd340, 16'sd32000};
        b.cmd = CMD_WRITE;
        b.idx = idx[15:0];
        b.x = 16'((idx % 16) * 20 + $urandom_range(0, 15) - 100);
        b.y = 16'((idx / 16) * 20 + $urandom_range(0, 15));
        r = $urandom_range(0, 9);
        if (r == 0) b.z = 0;
        else if (r == 1) begin
            b.x = 16'($urandom);
            b.y = 16'($urandom);
            b.z = 16'($urandom);
        end else b.z = bases[r % 4] + 16'($urandom_range(0, 30));
        return b;
    endfunction

    task automatic send_cmd(t_cmd c, int idx);
        cmd_beat_t b;
        b = '0;
        b.cmd = c;
        b.idx = idx[15:0];
        b.x = 16'($urandom);
        b.y = 16'($urandom);
        b.z = 16'($urandom);
        send(b);
    endtask

    task automatic read_any();
        send_cmd(CMD_READ, written_list[$urandom_range(0, written_list.size() - 1)]);
    endtask

    // Drain: let every owed result arrive, then a margin for write beats in flight
    task automatic wait_idle();
        in_ch.valid <= 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic configure(int min_sz, int wsz, int th, int dep, int w, int h);
        int vals[6];
        t_reg_idx regs[6];
        vals = '{min_sz, wsz, th, dep, w, h};
        regs = '{REG_MIN_SIZE, REG_WINDOW, REG_THRESHOLD, REG_DEPTH_ONLY, REG_IMG_WIDTH,
                 REG_IMG_HEIGHT};
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i][CFG_DATA_W-1:0];
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 0;
        area = ((w & 511) > 256 ? 256 : (w & 511)) * ((h & 511) > 256 ? 256 : (h & 511));
    endtask

    // One configuration: fill the image in use, then mixed traffic with two runs
    task automatic phase(int min_sz, int wsz, int th, int dep, int w, int h, bit hold);
        int r;
        wait_idle();
        configure(min_sz, wsz, th, dep, w, h);
        for (int i = 0; i < area; i++)
            if (!written[i]) send(make_point(i));
        for (int k = 0; k < 30; k++) begin
            if (hold && k == 15) hold_req = 1;
            r = $urandom_range(0, 19);
            if (k == 12 || k == 29) send_cmd(CMD_RUN, $urandom);
            else if (r < 8 && area > 0) send(make_point($urandom_range(0, area - 1)));
            else if (r < 11) send(make_point($urandom_range(0, STORE - 1)));
            else if (r < 19) read_any();
            else send_cmd(CMD_SPARE, $urandom);
        end
        for (int k = 0; k < 6; k++) read_any();
    endtask

    initial begin
        cmd_beat_t b;
        sb = new();
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.cmd = CMD_WRITE;
        in_ch.pixel_index = 0;
        in_ch.coord_x = 0;
        in_ch.coord_y = 0;
        in_ch.coord_z = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_MIN_SIZE;
        cfg_ch.data = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, top index, ignored command, reset thresholds
        configure(1000, 3, 50, 1, 8, 4);
        b = '{CMD_WRITE, 16'hFFFF, -16'sd32768, 16'sd32767, -16'sd1};
        send(b);
        b = '{CMD_WRITE, 16'd0, 16'sd32767, -16'sd32768, 16'sd0};
        send(b);
        b = '{CMD_WRITE, 16'd40, -16'sd1, 16'sd0, 16'sd32767};
        send(b);
        for (int i = 1; i < area; i++) send(make_point(i));
        send_cmd(CMD_SPARE, 5);
        send_cmd(CMD_READ, 16'hFFFF);
        send_cmd(CMD_READ, 0);
        send_cmd(CMD_RUN, 0);
        send_cmd(CMD_READ, 16'hFFFF);
        send_cmd(CMD_READ, 40);
        send_cmd(CMD_READ, 0);
        send_cmd(CMD_READ, 31);
        send_cmd(CMD_SPARE, 16'hFFFF);

        steady = 1;
        phase(0, 0, 0, 0, 16, 4, 0);
        steady = 0;
        phase(3, 15, 65535, 0, 5, 5, 1);
        phase(65536, 1, 100, 1, 256, 1, 0);
        steady = 1;
        phase(131071, 14, 40, 1, 1, 300, 0);
        steady = 0;
        phase(2, 3, 60, 1, 0, 9, 0);
        phase(4, 5, 200, 0, 511, 1, 0);
        phase(5, 7, 30, 1, 12, 10, 0);
        phase(1, 2, 65535, 1, 6, 6, 1);

        wait_idle();
        if (errors == 0) $display("PASS depth_island_removal_filter");
        else $display("FAIL depth_island_removal_filter");
        $finish;
    end
endmodule

@@ depth_island_removal_filter.f @@
+incdir+rtl
rtl/dirf_pkg.sv
rtl/dirf_in_if.sv
rtl/dirf_out_if.sv
rtl/dirf_cfg_if.sv
rtl/depth_island_removal_filter.sv
sim/tb_depth_island_removal_filter.sv
